>>> sv/lsbse_pkg.sv
// Shared types and constants for the LSB embed/extract block.
package lsbse_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int DATA_OFFSET_RESET   = 54;
    localparam int CFG_DATA_W          = 16;
    localparam int CFG_ADDR_W          = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET = 1'b1;

    localparam logic MODE_HIDE = 1'b0;

    localparam logic [7:0] MARK_START = 8'h02;
    localparam logic [7:0] MARK_END   = 8'h03;
    localparam logic [7:0] LSB_CLEAR  = 8'hFE;
    localparam logic [7:0] LSB_ONLY   = 8'h01;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_STX  = 3'd1,
        PH_TEXT = 3'd2,
        PH_ETX  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] bit_index;
        logic [7:0] char_shift;
    } t_state;

    typedef struct packed {
        logic [7:0] cover_byte;
        logic [7:0] text_byte;
        logic       text_empty;
        logic       last_cover;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       char_valid;
        logic       text_taken;
        logic       message_done;
        logic       marker_missing;
        logic       overflow;
        logic       last_out;
    } t_result;

endpackage

>>> sv/lsb_stego_embed_extract.sv
// Top level of the LSB embed/extract block: registers, handshake and config port.
//
// One image byte enters per word on the input channel (i_in_valid / o_in_stall)
// with the offered message character, its empty flag and the end-of-image flag.
// One result word leaves per input word on the output channel (o_out_valid /
// i_out_stall). Mode and header length are set through the write port (i_cfg_we,
// i_cfg_addr, i_cfg_data); the user must write them only while the block is idle.
// The block itself does not enforce this.
//
// A word is accepted when i_in_valid is high and o_in_stall is low. It sits
// in an input register, the embed/extract logic works on it combinationally,
// and its result is loaded into the output register when that register is
// free. A new word can be accepted every cycle while the receiver does not
// stall, so throughput is one word per clock; the only loop is the stream
// state (header count, phase, bit position, character) updated once a word.
// When the receiver stalls, the result stays in the output register and
// one more word waits in the input register; o_in_stall rises only when
// both are full. Reset empties both stages, sets hide mode, a 54-byte header
// and returns the stream state to the header phase. After a word with
// i_last_cover, the stream state returns to the header phase as well.
module lsb_stego_embed_extract
    import lsbse_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_cover_byte,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_text_empty,
    input  logic                  i_last_cover,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_char_valid,
    output logic                  o_text_taken,
    output logic                  o_message_done,
    output logic                  o_marker_missing,
    output logic                  o_overflow,
    output logic                  o_last_out
);

    logic                   r_mode;
    logic [OFFSET_BITS-1:0] r_data_offset;
    logic [OFFSET_BITS-1:0] r_header_count;
    logic [OFFSET_BITS-1:0] n_header_count;
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_in_valid;
    t_item                  r_item;
    logic                   r_out_valid;
    t_result                r_result;
    t_result                n_result;

    logic                   out_free;
    logic                   step;
    logic                   in_accept;
    logic [31:0]            cfg_wide;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_wide   = {{(32 - CFG_DATA_W){1'b0}}, i_cfg_data};

    lsbse_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .i_mode         (r_mode),
        .i_data_offset  (r_data_offset),
        .i_header_count (r_header_count),
        .i_state        (r_state),
        .i_item         (r_item),
        .o_header_count (n_header_count),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_HIDE;
            r_data_offset <= OFFSET_BITS'(DATA_OFFSET_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:   r_mode        <= i_cfg_data[0];
                CFG_OFFSET: r_data_offset <= cfg_wide[OFFSET_BITS-1:0];
                default:    r_mode        <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count     <= '0;
            r_state.phase      <= PH_HDR;
            r_state.bit_index  <= 3'd0;
            r_state.char_shift <= 8'h00;
        end else if (step) begin
            r_header_count <= n_header_count;
            r_state        <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.cover_byte <= i_cover_byte;
            r_item.text_byte  <= i_text_byte;
            r_item.text_empty <= i_text_empty;
            r_item.last_cover <= i_last_cover;
        end
        if (step) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_result.out_byte;
    assign o_char_valid     = r_result.char_valid;
    assign o_text_taken     = r_result.text_taken;
    assign o_message_done   = r_result.message_done;
    assign o_marker_missing = r_result.marker_missing;
    assign o_overflow       = r_result.overflow;
    assign o_last_out       = r_result.last_out;

`ifndef SYNTHESIS
    // A word that ends the image must leave the stream back in the header phase.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_item.last_cover)
        |=> (r_state.phase == PH_HDR && r_header_count == '0 && r_state.bit_index == 3'd0))
        else $error("stream state not cleared after last cover byte");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_done_vs_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.message_done && r_result.marker_missing))
        else $error("end marker and missing start marker in one word");

    a_done_vs_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.message_done && r_result.overflow))
        else $error("overflow flagged on the word that finished the message");

    a_taken_vs_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.text_taken && r_result.char_valid))
        else $error("hide and show results mixed in one word");
`endif

endmodule

>>> sv/lsbse_step.sv
// Per-word embed/extract logic: next stream state and the result word.
module lsbse_step
    import lsbse_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                   i_mode,
    input  logic [OFFSET_BITS-1:0] i_data_offset,
    input  logic [OFFSET_BITS-1:0] i_header_count,
    input  t_state                 i_state,
    input  t_item                  i_item,
    output logic [OFFSET_BITS-1:0] o_header_count,
    output t_state                 o_state,
    output t_result                o_result
);

    logic                   hide;
    logic [OFFSET_BITS-1:0] hc;
    t_phase                 ph;
    logic [2:0]             bi;
    logic [7:0]             sh;
    logic [7:0]             cur;
    t_result                res;

    assign hide = (i_mode == MODE_HIDE);

    always_comb begin
        hc  = i_header_count;
        ph  = i_state.phase;
        bi  = i_state.bit_index;
        sh  = i_state.char_shift;
        cur = MARK_START;
        res = '0;

        if (ph == PH_HDR) begin
            if (hc < i_data_offset) begin
                hc = hc + OFFSET_BITS'(1);
                res.out_byte = hide ? i_item.cover_byte : 8'h00;
            end else begin
                // Header finished: this same word is the first data word.
                ph = PH_STX;
                bi = 3'd0;
                sh = 8'h00;
            end
        end

        if (ph == PH_STX || ph == PH_TEXT || ph == PH_ETX) begin
            if (hide) begin
                case (ph)
                    PH_STX: begin
                        cur = MARK_START;
                    end
                    PH_TEXT: begin
                        if (bi == 3'd0) begin
                            if (i_item.text_empty) begin
                                ph = PH_ETX;
                                sh = MARK_END;
                            end else begin
                                sh = i_item.text_byte;
                                res.text_taken = 1'b1;
                            end
                        end
                        cur = sh;
                    end
                    default: begin
                        cur = MARK_END;
                    end
                endcase
                res.out_byte = (i_item.cover_byte & LSB_CLEAR) | ((cur >> bi) & LSB_ONLY);
                if (bi == 3'd7) begin
                    bi = 3'd0;
                    if (ph == PH_STX) begin
                        ph = PH_TEXT;
                    end else if (ph == PH_ETX) begin
                        ph = PH_DONE;
                        res.message_done = 1'b1;
                    end
                end else begin
                    bi = bi + 3'd1;
                end
            end else begin
                if (bi == 3'd0) begin
                    sh = 8'h00;
                end
                // Bits already set in the character stay set after a mode change.
                sh = sh | (8'(i_item.cover_byte[0]) << bi);
                if (bi == 3'd7) begin
                    bi = 3'd0;
                    if (ph == PH_STX) begin
                        if (sh != MARK_START) begin
                            res.marker_missing = 1'b1;
                            ph = PH_DONE;
                        end else begin
                            ph = PH_TEXT;
                        end
                    end else if (sh == MARK_END) begin
                        res.message_done = 1'b1;
                        ph = PH_DONE;
                    end else begin
                        res.out_byte   = sh;
                        res.char_valid = 1'b1;
                    end
                end else begin
                    bi = bi + 3'd1;
                end
            end
        end else if (ph != PH_HDR) begin
            res.out_byte = hide ? i_item.cover_byte : 8'h00;
        end

        res.last_out = i_item.last_cover;
        if (i_item.last_cover) begin
            if ((ph == PH_HDR || ph == PH_STX || ph == PH_TEXT || ph == PH_ETX)
                    && !res.message_done) begin
                res.overflow = 1'b1;
            end
            hc = '0;
            ph = PH_HDR;
            bi = 3'd0;
            sh = 8'h00;
        end
    end

    assign o_header_count     = hc;
    assign o_state.phase      = ph;
    assign o_state.bit_index  = bi;
    assign o_state.char_shift = sh;
    assign o_result           = res;

endmodule
